// File: rtl/salgs_pkg.sv
// Shared widths, payload structs, cell control and sequencer states for the gap splitter.
package salgs_pkg;

  localparam int MAX_ENTRIES_DEF = 32;
  localparam int ENTRY_CNT_W     = 6;
  localparam int ID_W            = 6;
  localparam int COUNT_W         = 16;
  localparam int KEY_W           = 17;
  localparam int VALUE_W         = 6;

  typedef struct packed {
    logic [ID_W-1:0]    sample_id;
    logic [COUNT_W-1:0] start_count;
    logic [COUNT_W-1:0] end_count;
  } in_item_t;

  typedef struct packed {
    logic               is_count;
    logic               group_high;
    logic [VALUE_W-1:0] value;
    logic               last_of_run;
  } result_t;

  // key is a two's complement difference; compare it through $signed
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } entry_t;

  typedef struct packed {
    logic load;
    logic sort_en;
    logic odd_phase;
    logic rotate;
  } cell_ctrl_t;

  typedef struct packed {
    logic odd_slot;
    logic has_left;
    logic has_right;
    logic is_last;
  } cell_pos_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SORT,
    ST_SCAN,
    ST_SEEK,
    ST_HCOUNT,
    ST_HIGH,
    ST_LCOUNT,
    ST_LOW
  } state_t;

endpackage

// File: rtl/salgs_cell.sv
// One slot of the row: stored entry, working copy, neighbor compare-exchange and rotation.
module salgs_cell (
  input  logic                 clk,
  input  salgs_pkg::cell_ctrl_t ctrl,
  input  salgs_pkg::cell_pos_t  pos,
  input  logic                 wr_en,
  input  salgs_pkg::entry_t    wr_data,
  input  salgs_pkg::entry_t    left,
  input  salgs_pkg::entry_t    right,
  input  salgs_pkg::entry_t    wrap,
  output salgs_pkg::entry_t    work
);
  import salgs_pkg::*;

  entry_t store;
  entry_t sorted;
  logic   is_left;

  // odd-even transposition: swap only on strict less, which keeps equal keys in order
  always_comb begin
    is_left = (pos.odd_slot == ctrl.odd_phase);
    sorted  = work;
    if (is_left) begin
      if (pos.has_right && ($signed(right.key) < $signed(work.key))) begin
        sorted = right;
      end
    end else begin
      if (pos.has_left && ($signed(work.key) < $signed(left.key))) begin
        sorted = left;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store <= wr_data;
    end
    if (ctrl.load) begin
      work <= store;
    end else if (ctrl.sort_en) begin
      work <= sorted;
    end else if (ctrl.rotate) begin
      work <= pos.is_last ? wrap : right;
    end
  end

endmodule

// File: rtl/salgs_ctrl.sv
// Sequencer: set counting, sort rounds, gap scan, seek to the split and result emission.
module salgs_ctrl #(
  parameter int MAX_ENTRIES = salgs_pkg::MAX_ENTRIES_DEF,
  parameter int N_W         = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cfg_wr,
  input  logic [salgs_pkg::ENTRY_CNT_W-1:0] cfg_data,
  input  salgs_pkg::entry_t                 head,
  output logic [N_W-1:0]                    n_run,
  output salgs_pkg::cell_ctrl_t             ctrl,
  output logic                              result_strobe,
  output salgs_pkg::result_t                result
);
  import salgs_pkg::*;

  state_t                 state, state_next;
  logic [ENTRY_CNT_W-1:0] entry_count, entry_count_next;
  logic [ENTRY_CNT_W-1:0] items_received, items_received_next;
  logic [N_W-1:0]         n_run_next;
  logic [N_W-1:0]         cnt, cnt_next;
  logic [N_W-1:0]         split, split_next;
  logic [KEY_W-1:0]       best, best_next;
  logic [KEY_W-1:0]       prev, prev_next;

  logic [N_W-1:0]         n_cur;
  logic [ENTRY_CNT_W-1:0] rcv_inc;
  logic                   final_item;
  logic [N_W-1:0]         n_m1;
  logic [N_W-1:0]         hi_cnt;
  logic [N_W-1:0]         hi_m1;
  logic signed [KEY_W:0]  gap;

  always_comb begin
    if (entry_count == '0) begin
      n_cur = N_W'(1);
    end else if (entry_count > ENTRY_CNT_W'(MAX_ENTRIES)) begin
      n_cur = N_W'(MAX_ENTRIES);
    end else begin
      n_cur = N_W'(entry_count);
    end
  end

  assign rcv_inc    = items_received + ENTRY_CNT_W'(1);
  assign final_item = (rcv_inc >= ENTRY_CNT_W'(n_cur));
  assign n_m1       = n_run - N_W'(1);
  assign hi_cnt     = n_run - split - N_W'(1);
  assign hi_m1      = hi_cnt - N_W'(1);
  assign gap        = $signed({head.key[KEY_W-1], head.key}) - $signed({prev[KEY_W-1], prev});
  assign busy       = (state != ST_IDLE);

  always_comb begin
    state_next          = state;
    entry_count_next    = entry_count;
    items_received_next = items_received;
    n_run_next          = n_run;
    cnt_next            = cnt;
    split_next          = split;
    best_next           = best;
    prev_next           = prev;
    ctrl                = '0;
    result_strobe       = 1'b0;
    result              = '0;

    if (cfg_wr) begin
      entry_count_next = cfg_data;
    end

    case (state)
      ST_IDLE: begin
        if (start) begin
          if (final_item) begin
            items_received_next = '0;
            n_run_next          = n_cur;
            state_next          = ST_LOAD;
          end else begin
            items_received_next = rcv_inc;
          end
        end
      end
      ST_LOAD: begin
        ctrl.load  = 1'b1;
        cnt_next   = '0;
        best_next  = '0;
        split_next = '0;
        state_next = ST_SORT;
      end
      ST_SORT: begin
        ctrl.sort_en   = 1'b1;
        ctrl.odd_phase = cnt[0];
        if (cnt == n_m1) begin
          cnt_next   = '0;
          state_next = ST_SCAN;
        end else begin
          cnt_next = cnt + N_W'(1);
        end
      end
      ST_SCAN: begin
        // head walks the sorted row; track the first strictly largest gap
        ctrl.rotate = 1'b1;
        prev_next   = head.key;
        if ((cnt != '0) && (gap > $signed({1'b0, best}))) begin
          best_next  = gap[KEY_W-1:0];
          split_next = cnt - N_W'(1);
        end
        if (cnt == n_m1) begin
          cnt_next   = '0;
          state_next = ST_SEEK;
        end else begin
          cnt_next = cnt + N_W'(1);
        end
      end
      ST_SEEK: begin
        ctrl.rotate = 1'b1;
        if (cnt == split) begin
          cnt_next   = '0;
          state_next = ST_HCOUNT;
        end else begin
          cnt_next = cnt + N_W'(1);
        end
      end
      ST_HCOUNT: begin
        result_strobe     = 1'b1;
        result.is_count   = 1'b1;
        result.group_high = 1'b1;
        result.value      = VALUE_W'(hi_cnt);
        cnt_next          = '0;
        state_next        = (hi_cnt == '0) ? ST_LCOUNT : ST_HIGH;
      end
      ST_HIGH: begin
        result_strobe     = 1'b1;
        result.group_high = 1'b1;
        result.value      = VALUE_W'(head.id);
        ctrl.rotate       = 1'b1;
        if (cnt == hi_m1) begin
          cnt_next   = '0;
          state_next = ST_LCOUNT;
        end else begin
          cnt_next = cnt + N_W'(1);
        end
      end
      ST_LCOUNT: begin
        result_strobe   = 1'b1;
        result.is_count = 1'b1;
        result.value    = VALUE_W'(split + N_W'(1));
        cnt_next        = '0;
        state_next      = ST_LOW;
      end
      ST_LOW: begin
        result_strobe      = 1'b1;
        result.value       = VALUE_W'(head.id);
        result.last_of_run = (cnt == split);
        ctrl.rotate        = 1'b1;
        if (cnt == split) begin
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + N_W'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count    <= ENTRY_CNT_W'(1);
      items_received <= '0;
    end else begin
      entry_count    <= entry_count_next;
      items_received <= items_received_next;
    end
    n_run <= n_run_next;
    cnt   <= cnt_next;
    split <= split_next;
    best  <= best_next;
    prev  <= prev_next;
  end

endmodule

// File: rtl/sort_and_largest_gap_split_top.sv
// Top level of the largest-gap two-group splitter: row of cells plus sequencer.
//
// Usage: drive item and raise start; a beat is taken at each edge where start is high
// and busy is low. Items that do not close a set are taken one per cycle and give no
// result. The item that brings the count to entry_count closes the set: busy rises and
// the row of cells copies the stored keys, runs n odd-even transposition rounds, then
// rotates past cell 0 once to find the split and again to read out the groups.
// With n items in the set, the first result follows the load, the sort rounds, the scan
// and the seek to the split, and n+2 result beats follow on back-to-back cycles: high
// count, high ids, low count, low ids, the last one flagged by last_of_run. busy stays
// high through the sort rounds and the two passes through the cell chain.
// Each result beat stands on result for one cycle with result_strobe high; the
// receiver cannot stall, so nothing is held back. cfg_ready is always high; write
// entry_count only while busy is low and no set is partly loaded. Reset clears the
// sequencer, the item count and sets entry_count to 1; the stored entries keep
// whatever they hold and a slot must be written before a set reads it.
module sort_and_largest_gap_split_top #(
  parameter int MAX_ENTRIES = salgs_pkg::MAX_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  salgs_pkg::in_item_t               item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [salgs_pkg::ENTRY_CNT_W-1:0] cfg_data,
  output logic                              result_strobe,
  output salgs_pkg::result_t                result
);
  import salgs_pkg::*;

  localparam int N_W = $clog2(MAX_ENTRIES + 1);

  logic                   accept;
  logic [N_W-1:0]         n_run;
  cell_ctrl_t             ctrl;
  entry_t                 wr_data;
  entry_t                 work [MAX_ENTRIES];
  entry_t                 right_in [MAX_ENTRIES];
  entry_t                 left_in [MAX_ENTRIES];
  cell_pos_t              pos [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] wr_en;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // key is the signed difference of the counts, one bit wider than they are
  assign wr_data.key = {1'b0, item.end_count} - {1'b0, item.start_count};
  assign wr_data.id  = item.sample_id;

  salgs_ctrl #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .N_W        (N_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cfg_wr       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .head         (work[0]),
    .n_run        (n_run),
    .ctrl         (ctrl),
    .result_strobe(result_strobe),
    .result       (result)
  );

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    // ids outside one..MAX_ENTRIES hit no slot and write nothing
    assign wr_en[i]         = accept && (item.sample_id == ID_W'(i + 1));
    assign pos[i].odd_slot  = 1'(i % 2);
    assign pos[i].has_left  = (i != 0) && (N_W'(i) < n_run);
    assign pos[i].has_right = (N_W'(i + 1) < n_run);
    assign pos[i].is_last   = (N_W'(i + 1) == n_run);

    if (i == 0) begin : g_first
      assign left_in[i] = '0;
    end else begin : g_inner_l
      assign left_in[i] = work[i-1];
    end
    if (i == MAX_ENTRIES - 1) begin : g_end
      assign right_in[i] = '0;
    end else begin : g_inner_r
      assign right_in[i] = work[i+1];
    end

    salgs_cell u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .pos    (pos[i]),
      .wr_en  (wr_en[i]),
      .wr_data(wr_data),
      .left   (left_in[i]),
      .right  (right_in[i]),
      .wrap   (work[0]),
      .work   (work[i])
    );
  end

`ifndef SYNTH
  // results come only out of a running set
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> busy)
    else $error("result beat while idle");

  // the flagged last beat ends the set
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.last_of_run) |=> !busy)
    else $error("busy after last beat");

  // a set starts only from an accepted beat
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy without a start beat");

  // the high count is the first beat of every set
  a_first_high: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !$past(result_strobe)) |-> (result.is_count && result.group_high))
    else $error("set does not open with the high count");
`endif

endmodule

// File: dv/tb_sort_and_largest_gap_split_top.sv
// Self-checking testbench for the largest-gap two-group splitter.
`timescale 1ns / 1ps

module tb_sort_and_largest_gap_split_top;
  import salgs_pkg::*;

  localparam int NSLOT        = MAX_ENTRIES_DEF;
  localparam int ITEM_TARGET  = 370;
  // A stall limit well above the busy time of a full set
  // plus the config pause and sender gaps only trips on a real hang.
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 4 * NSLOT + 16;
  localparam int CFG_SETTLE   = 8;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  in_item_t item = '0;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [ENTRY_CNT_W-1:0] cfg_data = '0;
  logic     result_strobe;
  result_t  result;

  sort_and_largest_gap_split_top dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .result_strobe (result_strobe),
    .result        (result)
  );

  always #10 clk = ~clk;

  // Mirror of the block: configured set size, per-slot key and id stores,
  // and how many beats of the current set have been taken.
  logic [ENTRY_CNT_W-1:0]  set_size = 6'd1;
  logic signed [KEY_W-1:0] key_mem [NSLOT];
  logic [ID_W-1:0]         id_mem  [NSLOT];
  logic [ENTRY_CNT_W-1:0]  set_fill = '0;

  result_t split_words[$];   // expected result beats, oldest first
  int      fail_count = 0;
  int      sent_beats = 0;
  int      stall_cycles = 0;
  bit      gaps_on = 1'b1;

  // Clamp the programmed count to the range the block actually uses.
  function automatic int active_size();
    if (set_size == 0) return 1;
    if (set_size > NSLOT) return NSLOT;
    return set_size;
  endfunction

  // Store one accepted sample; on the beat that closes the set, sort a copy
  // of the slots, locate the first widest positive gap and queue the readout.
  task automatic apply_sample(input in_item_t it);
    logic signed [KEY_W-1:0] keys [NSLOT];
    logic [ID_W-1:0]         ids  [NSLOT];
    logic signed [KEY_W-1:0] k_hold;
    logic [ID_W-1:0]         id_hold;
    int n, p, q, cut, widest, step;
    n = active_size();
    // Out-of-range ids leave the stores alone but still count toward the set.
    if (it.sample_id >= 1 && it.sample_id <= NSLOT) begin
      key_mem[it.sample_id - 1] = {1'b0, it.end_count} - {1'b0, it.start_count};
      id_mem[it.sample_id - 1]  = it.sample_id;
    end
    set_fill = set_fill + 1'b1;
    if (set_fill < n) return;
    set_fill = '0;

    for (p = 0; p < n; p++) begin
      keys[p] = key_mem[p];
      ids[p]  = id_mem[p];
    end
    // Insertion sort; the strict compare keeps equal keys in slot order.
    for (p = 1; p < n; p++) begin
      k_hold  = keys[p];
      id_hold = ids[p];
      q = p - 1;
      while (q >= 0 && keys[q] > k_hold) begin
        keys[q + 1] = keys[q];
        ids[q + 1]  = ids[q];
        q--;
      end
      keys[q + 1] = k_hold;
      ids[q + 1]  = id_hold;
    end
    // With no positive gap the cut stays after the first entry.
    widest = 0;
    cut = 0;
    for (p = 0; p + 1 < n; p++) begin
      step = int'(keys[p + 1]) - int'(keys[p]);
      if (step > widest) begin
        widest = step;
        cut = p;
      end
    end

    split_words.push_back('{is_count: 1'b1, group_high: 1'b1,
                            value: VALUE_W'(n - cut - 1), last_of_run: 1'b0});
    for (p = cut + 1; p < n; p++)
      split_words.push_back('{is_count: 1'b0, group_high: 1'b1,
                              value: ids[p], last_of_run: 1'b0});
    split_words.push_back('{is_count: 1'b1, group_high: 1'b0,
                            value: VALUE_W'(cut + 1), last_of_run: 1'b0});
    for (p = 0; p <= cut; p++)
      split_words.push_back('{is_count: 1'b0, group_high: 1'b0,
                              value: ids[p], last_of_run: (p == cut)});
  endtask

  // Present one sample and hold it until a beat is taken. Leave start high
  // unless a gap is drawn, so back-to-back beats never drop start.
  task automatic send_item(input in_item_t it);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    apply_sample(it);
    sent_beats++;
    if (gaps_on && $urandom_range(99) < 25) begin
      start <= 1'b0;
      item  <= in_item_t'({$urandom, $urandom});
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Drain every pending result, let the sequencer settle, then write the count.
  task automatic write_entry_count(input logic [ENTRY_CNT_W-1:0] cnt);
    start <= 1'b0;
    while (split_words.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cnt;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    set_size = cnt;
  endtask

  function automatic in_item_t mk_item(input int id, input int st, input int en);
    mk_item.sample_id   = ID_W'(id);
    mk_item.start_count = COUNT_W'(st);
    mk_item.end_count   = COUNT_W'(en);
  endfunction

  // Single-entry sets: reset count, zero count clamped up, out-of-range ids.
  task automatic test_single_entry_sets();
    send_item(mk_item(1, 0, 0));          // reset count of one, empty high group
    send_item(mk_item(0, 5, 7));          // id zero writes nothing, still closes
    send_item(mk_item(63, 1, 2));         // id above range, same
    write_entry_count(6'd0);              // zero clamps to one
    send_item(mk_item(1, 65535, 0));
    send_item(mk_item(1, 0, 65535));
  endtask

  // Ties with no positive gap, a repeated id, and the first of two equal gaps.
  task automatic test_ties_and_repeats();
    write_entry_count(6'd2);
    send_item(mk_item(2, 10, 10));
    send_item(mk_item(1, 3, 3));
    write_entry_count(6'd3);
    send_item(mk_item(3, 0, 100));
    send_item(mk_item(2, 0, 5));
    send_item(mk_item(2, 0, 200));        // later beat overwrites the slot
  endtask

  // Widest key span: most negative and most positive differences in one set.
  task automatic test_key_extremes();
    write_entry_count(6'd4);
    send_item(mk_item(4, 65535, 0));
    send_item(mk_item(1, 0, 65535));
    send_item(mk_item(33, 1, 1));         // ignored slot, counted beat
    send_item(mk_item(3, 7, 7));
  endtask

  // Random sets. The first one fills every slot so later sets never read a
  // slot that was never written; after that, ids may be anything.
  task automatic test_random_sets();
    logic [ENTRY_CNT_W-1:0] cnt;
    int  order [NSLOT];
    int  n, mode, p, pick, tmp;
    bit  first_set, broken;
    in_item_t it;
    first_set = 1'b1;
    while (sent_beats < ITEM_TARGET) begin
      if (first_set) begin
        write_entry_count(6'd63);         // above range, clamps to the maximum
      end else if ($urandom_range(1)) begin
        case ($urandom_range(9))
          0:       cnt = 6'd0;
          1:       cnt = 6'd63;
          2:       cnt = 6'(NSLOT);
          3:       cnt = 6'($urandom_range(NSLOT + 1, 62));
          4:       cnt = 6'($urandom_range(13, NSLOT - 1));
          default: cnt = 6'($urandom_range(1, 12));
        endcase
        write_entry_count(cnt);
      end
      // Hold one long stretch with the sender never pausing.
      gaps_on = !(sent_beats >= 160 && sent_beats < 240);
      n = active_size();
      mode = $urandom_range(3);
      broken = !first_set && ($urandom_range(4) == 0);
      for (p = 0; p < NSLOT; p++) order[p] = p + 1;
      for (p = n - 1; p > 0; p--) begin
        pick = $urandom_range(p);
        tmp = order[p];
        order[p] = order[pick];
        order[pick] = tmp;
      end
      for (p = 0; p < n; p++) begin
        it.sample_id = broken ? ID_W'($urandom_range(63)) : ID_W'(order[p]);
        case (mode)
          0: begin
            it.start_count = COUNT_W'($urandom);
            it.end_count   = COUNT_W'($urandom);
          end
          1: begin                         // narrow range: many ties
            it.start_count = COUNT_W'($urandom_range(3));
            it.end_count   = COUNT_W'($urandom_range(3));
          end
          2: begin                         // rails on one side
            it.start_count = {COUNT_W{$urandom_range(1) == 1}};
            it.end_count   = COUNT_W'($urandom);
          end
          default: begin
            it.start_count = COUNT_W'($urandom_range(1000));
            it.end_count   = {COUNT_W{$urandom_range(1) == 1}};
          end
        endcase
        send_item(it);
      end
      first_set = 1'b0;
    end
  endtask

  function automatic void check_field(input string field, input logic [7:0] got,
                                      input logic [7:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
      fail_count++;
    end
  endfunction

  // Take each result beat at the edge that ends its cycle and compare it
  // against the oldest expectation.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_strobe) begin
      if (split_words.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, got %p", $time, result);
        fail_count++;
      end else begin
        want = split_words.pop_front();
        check_field("is_count", result.is_count, want.is_count);
        check_field("group_high", result.group_high, want.group_high);
        check_field("value", result.value, want.value);
        check_field("last_of_run", result.last_of_run, want.last_of_run);
      end
    end
  end

  // Count cycles with no beat on any channel; a long run of them is a hang.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("[sort_and_largest_gap_split_top] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_entry_sets();
    test_ties_and_repeats();
    test_key_extremes();
    test_random_sets();

    // Drop start, wait out every expected beat, then watch for strays.
    start <= 1'b0;
    while (split_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[sort_and_largest_gap_split_top] OK");
    end else begin
      $display("[sort_and_largest_gap_split_top] ERROR");
    end
    $finish;
  end

endmodule
